// ----- hdl/hexcrc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hexcrc_pkg
// Shared types, register indexes and character decoding for the hex text CRC
// checker.
// ----------------------------------------------------------------------------
package hexcrc_pkg;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 1;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GENERATOR   = 1'b0,
      CSR_VERIFY_MODE = 1'b1
   } csr_index_type;

   localparam int CSR_DATA_W   = 16;
   localparam int CHAR_W       = 8;
   localparam int NIBBLE_W     = 4;
   localparam int CRC_OUT_W    = 16;
   localparam int RSP_DATA_W   = 24;   // crc_value, format_error, check_pass, zero pad
   localparam logic [CSR_DATA_W-1:0] GENERATOR_RESET = 16'h0589;

   // ASCII codes bounding the data characters
   localparam logic [CHAR_W-1:0] ASCII_0 = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_9 = 8'h39;
   localparam logic [CHAR_W-1:0] ASCII_A = 8'h41;
   localparam logic [CHAR_W-1:0] ASCII_F = 8'h46;
   localparam logic [NIBBLE_W-1:0] NIBBLE_A = 4'hA;

   // Decoded character: data flag plus its four-bit value
   typedef struct packed {
      logic                is_data;
      logic [NIBBLE_W-1:0] nibble;
   } hex_digit_type;

   // Uppercase hex digits only; everything else is a format error
   function automatic hex_digit_type decode_hex(input logic [CHAR_W-1:0] ch);
      hex_digit_type d;
      logic [CHAR_W-1:0] ofs;
      d   = '{is_data: 1'b0, nibble: '0};
      ofs = '0;
      if (ch inside {[ASCII_0:ASCII_9]}) begin
         ofs      = ch - ASCII_0;
         d.is_data = 1'b1;
         d.nibble = ofs[NIBBLE_W-1:0];
      end else if (ch inside {[ASCII_A:ASCII_F]}) begin
         ofs      = ch - ASCII_A;
         d.is_data = 1'b1;
         d.nibble = ofs[NIBBLE_W-1:0] + NIBBLE_A;
      end
      return d;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/hexcrc_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hexcrc_step
// One character of CRC work: decodes the ASCII digit and shifts its four bits
// MSB first through the CRC remainder.
// ----------------------------------------------------------------------------
module hexcrc_step #(
   parameter int CRC_WIDTH = 16
) (
   input  wire logic [hexcrc_pkg::CHAR_W-1:0] hex_char,
   input  wire logic [CRC_WIDTH-1:0]          remainder,
   input  wire logic [CRC_WIDTH-1:0]          generator,
   output logic                               is_data,
   output logic [CRC_WIDTH-1:0]               remainder_next
);
   import hexcrc_pkg::*;

   hex_digit_type digit;

   always_comb begin
      logic [CRC_WIDTH-1:0] r;
      logic                 fb;
      digit = decode_hex(hex_char);
      r     = remainder;
      // Four dependent LFSR steps, nibble MSB first
      for (int b = NIBBLE_W - 1; b >= 0; b--) begin
         fb = r[CRC_WIDTH-1] ^ digit.nibble[b];
         r  = {r[CRC_WIDTH-2:0], 1'b0} ^ (fb ? generator : '0);
      end
      // Non-data characters leave the remainder alone
      is_data        = digit.is_data;
      remainder_next = digit.is_data ? r : remainder;
   end

endmodule
`default_nettype wire

// ----- hdl/hex_text_crc16_check.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hex_text_crc16_check
// MSB-first CRC over a message written as ASCII hex text, with compute and
// verify modes.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle unless rsp back-pressure stalls it,
// and each yields one response. The response is registered: a request passes
// through the input register and then the response register to reach rsp.
// The decode and four-bit CRC update run combinationally from the input
// register into the remainder and the response register. The loop through
// the remainder register sets the rate of one character per cycle. req_tlast
// ends a message; its response carries rsp_tlast and the running remainder
// and error flag clear for the next one.
// Only '0'-'9' and 'A'-'F' are data; any other byte sets a sticky format
// error for the rest of the message. csr writes (index 0 generator,
// index 1 verify mode) must be made while no request is in flight.
// ----------------------------------------------------------------------------
module hex_text_crc16_check #(
   parameter int CRC_WIDTH = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request stream
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [hexcrc_pkg::CHAR_W-1:0]       req_tdata,   // [7:0] hex_char
   input  wire logic                                req_tlast,   // last_char
   // Response stream
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [hexcrc_pkg::RSP_DATA_W-1:0]        rsp_tdata,   // [15:0] crc_value,
                                                                 // [16] format_error,
                                                                 // [17] check_pass
   output logic                                     rsp_tlast,   // message_end
   // Configuration writes
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [hexcrc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [hexcrc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import hexcrc_pkg::*;

   localparam int PAD_W = RSP_DATA_W - CRC_OUT_W - 2;

   // Configuration registers
   logic [CSR_DATA_W-1:0] generator_ff;
   logic                  verify_mode_ff;

   // Input stage
   logic              s1_valid_ff;
   logic [CHAR_W-1:0] s1_char_ff;
   logic              s1_last_ff;

   // Running state
   logic [CRC_WIDTH-1:0] rem_ff, rem_in;
   logic                 bad_ff, bad_in;

   // Response register
   logic                 out_valid_ff;
   logic [CRC_OUT_W-1:0] out_crc_ff;
   logic                 out_err_ff;
   logic                 out_pass_ff;
   logic                 out_last_ff;

   logic                 advance;
   logic                 is_data;
   logic [CRC_WIDTH-1:0] rem_next;
   logic [CRC_WIDTH-1:0] gen_w;
   logic                 err_next;
   logic                 pass_next;

   // Handshakes
   assign csr_ready  = 1'b1;
   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   // Configuration write port
   always_ff @(posedge clock) begin
      if (reset) begin
         generator_ff   <= GENERATOR_RESET;
         verify_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_GENERATOR:   generator_ff   <= csr_wdata;
            CSR_VERIFY_MODE: verify_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_char_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

   // Generator resized to the CRC width; bits above 16 are zero
   assign gen_w = CRC_WIDTH'(32'(generator_ff));

   hexcrc_step #(
      .CRC_WIDTH(CRC_WIDTH)
   ) u_step (
      .hex_char       (s1_char_ff),
      .remainder      (rem_ff),
      .generator      (gen_w),
      .is_data        (is_data),
      .remainder_next (rem_next)
   );

   // Result and next state for the character in the input register
   always_comb begin
      err_next  = bad_ff || !is_data;
      pass_next = s1_last_ff && verify_mode_ff && (rem_next == '0) && !err_next;
      rem_in    = rem_ff;
      bad_in    = bad_ff;
      if (advance) begin
         rem_in = s1_last_ff ? '0 : rem_next;
         bad_in = s1_last_ff ? 1'b0 : err_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         bad_ff <= 1'b0;
      end else begin
         rem_ff <= rem_in;
         bad_ff <= bad_in;
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_crc_ff  <= CRC_OUT_W'(32'(rem_next));
         out_err_ff  <= err_next;
         out_pass_ff <= pass_next;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, out_pass_ff, out_err_ff, out_crc_ff};
   assign rsp_tlast  = out_last_ff;

   // A message end leaves the running state cleared
   assert property (@(posedge clock) disable iff (reset)
      (advance && s1_last_ff) |=> (rem_ff == '0 && !bad_ff))
      else $error("state not cleared after message end");

   // A pass is only reported on an error-free final character in verify mode
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_pass_ff) |-> (out_last_ff && !out_err_ff && verify_mode_ff))
      else $error("check_pass without verify mode, message end or clean message");

   // An empty input register always takes a request
   assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("request stalled with empty input register");

   // A request held in the input register moves on as soon as the response slot frees
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (!rsp_tvalid || rsp_tready)) |=> rsp_tvalid)
      else $error("response register not loaded");

endmodule
`default_nettype wire

// ----- tb/hex_text_crc16_check_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_text_crc16_check_tb
// Self-checking bench for the hex text CRC checker. A directed table covers
// the character boundaries, message end, format errors and both modes. Random
// messages follow, most of them well-formed hex digits (with a correct stored
// CRC in verify mode) and the rest broken or noise, over several generator
// settings. Every response is checked in order against its typed table value
// or an in-bench bit-serial CRC model, with random stalls on both streams.
// ----------------------------------------------------------------------------
module hex_text_crc16_check_tb;
   import hexcrc_pkg::*;

   localparam int  LIMIT_NS     = 10_000_000;
   localparam int  PHASE_ITEMS  = 175;
   localparam int  NUM_PHASES   = 8;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;
   typedef enum logic [1:0] {MSG_GOOD, MSG_BROKEN, MSG_NOISE} msg_kind_type;

   // One response, most significant field first
   typedef struct packed {
      logic [CRC_OUT_W-1:0] crc_value;
      logic                 format_error;
      logic                 check_pass;
      logic                 message_end;
   } crc_result_type;

   typedef struct packed {
      row_kind_type          kind;
      csr_index_type         csr_sel;
      logic [CSR_DATA_W-1:0] value;      // char in [7:0] for requests
      logic                  is_last;
      logic                  typed;
      crc_result_type        want;
   } dir_row_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [CHAR_W-1:0]       req_tdata;
   logic                    req_tlast;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_valid;
   logic                    csr_ready;
   csr_index_type           csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   // Model state and shadow registers
   logic [CRC_OUT_W-1:0]    crc_state;
   logic                    bad_char_seen;
   logic [CSR_DATA_W-1:0]   gen_poly;
   logic                    verify_on;

   crc_result_type          crc_expect_q[$];
   dir_row_type             dir_rows[$];
   int                      fail_count;
   bit                      tx_idle_on;
   bit                      rx_idle_on;
   int                      rx_hold_cycles;

   hex_text_crc16_check dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("DONE: errors detected");
      $finish;
   end

   // Four message bits, MSB first, through the CRC register
   function automatic logic [CRC_OUT_W-1:0] crc_shift_nibble(
         input logic [CRC_OUT_W-1:0] r, input logic [NIBBLE_W-1:0] nib,
         input logic [CSR_DATA_W-1:0] g);
      logic fb;
      for (int b = NIBBLE_W - 1; b >= 0; b--) begin
         fb = r[CRC_OUT_W-1] ^ nib[b];
         r  = r << 1;
         if (fb) begin
            r = r ^ g;
         end
      end
      return r;
   endfunction

   // {is_digit, value}; only '0'-'9' and 'A'-'F' count
   function automatic logic [NIBBLE_W:0] char_nibble(input logic [CHAR_W-1:0] ch);
      logic [CHAR_W-1:0] d;
      d = '0;
      if (ch >= "0" && ch <= "9") begin
         d = ch - "0";
         return {1'b1, d[NIBBLE_W-1:0]};
      end
      if (ch >= "A" && ch <= "F") begin
         d = ch - "A" + 8'd10;
         return {1'b1, d[NIBBLE_W-1:0]};
      end
      return '0;
   endfunction

   function automatic logic [CHAR_W-1:0] hex_ascii(input logic [NIBBLE_W-1:0] nib);
      if (nib < 4'd10) begin
         return "0" + {4'd0, nib};
      end
      return "A" + {4'd0, nib} - 8'd10;
   endfunction

   // Advance the model by one accepted character
   function automatic crc_result_type predict_crc_result(input logic [CHAR_W-1:0] ch,
                                                         input logic is_last);
      crc_result_type    res;
      logic [NIBBLE_W:0] dig;
      dig = char_nibble(ch);
      if (dig[NIBBLE_W]) begin
         crc_state = crc_shift_nibble(crc_state, dig[NIBBLE_W-1:0], gen_poly);
      end else begin
         bad_char_seen = 1'b1;
      end
      res.crc_value    = crc_state;
      res.format_error = bad_char_seen;
      res.check_pass   = is_last && verify_on && (crc_state == '0) && !bad_char_seen;
      res.message_end  = is_last;
      if (is_last) begin
         crc_state     = '0;
         bad_char_seen = 1'b0;
      end
      return res;
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   // Offer one request after a random gap; predict at acceptance
   task automatic push_char(input logic [CHAR_W-1:0] ch, input logic is_last,
                            input logic typed, input crc_result_type want);
      int             gap;
      crc_result_type pred;
      gap = tx_idle_on ? $urandom_range(0, 19) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = predict_crc_result(ch, is_last);
      crc_expect_q.push_back(typed ? want : pred);
   endtask

   // Drop valid, wait for all responses, then let the pipe empty
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (crc_expect_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_put(input csr_index_type sel, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (sel)
         CSR_GENERATOR:   gen_poly  = data;
         CSR_VERIFY_MODE: verify_on = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic req_row(input logic [CHAR_W-1:0] ch, input logic is_last,
                          input logic typed, input logic [CRC_OUT_W-1:0] crc,
                          input logic fmt, input logic ok, input logic mend);
      dir_rows.push_back('{ROW_REQ, CSR_GENERATOR, {8'd0, ch}, is_last, typed,
                           '{crc, fmt, ok, mend}});
   endtask

   task automatic csr_row(input csr_index_type sel, input logic [CSR_DATA_W-1:0] data);
      dir_rows.push_back('{ROW_CSR, sel, data, 1'b0, 1'b0, '0});
   endtask

   // Build and send one message; returns its length
   task automatic send_message(input msg_kind_type kind, output int n_sent);
      logic [CHAR_W-1:0]    msg[$];
      logic [CRC_OUT_W-1:0] r;
      logic [NIBBLE_W-1:0]  nib;
      int                   len;
      int                   pos;
      r   = '0;
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      if (kind == MSG_NOISE) begin
         repeat (len) msg.push_back(CHAR_W'($urandom_range(0, 255)));
      end else begin
         repeat (len) begin
            nib = NIBBLE_W'($urandom_range(0, 15));
            msg.push_back(hex_ascii(nib));
            r = crc_shift_nibble(r, nib, gen_poly);
         end
         // stored CRC, most significant digit first
         if (verify_on) begin
            for (int k = 3; k >= 0; k--) begin
               msg.push_back(hex_ascii(r[4*k +: 4]));
            end
         end
         if (kind == MSG_BROKEN) begin
            pos = $urandom_range(0, msg.size() - 1);
            if ($urandom_range(0, 1) == 0) begin
               msg[pos] = CHAR_W'($urandom_range(0, 255));
            end else begin
               msg[pos] = msg[pos] ^ (8'h01 << $urandom_range(0, 7));
            end
         end
      end
      for (int i = 0; i < msg.size(); i++) begin
         push_char(msg[i], i == msg.size() - 1, 1'b0, '0);
      end
      n_sent = msg.size();
   endtask

   // Response side: random ready gaps, plus a long hold when asked
   initial begin
      int n;
      int gap;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (rx_hold_cycles > 0) begin
            n = rx_hold_cycles;
            rx_hold_cycles = 0;
            repeat (n) begin
               @(negedge clock);
               rsp_tready <= 1'b0;
            end
         end
         gap = rx_idle_on ? $urandom_range(0, 19) : 0;
         repeat (gap) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Response checker
   always @(posedge clock) begin
      crc_result_type got;
      crc_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[15:0], rsp_tdata[16], rsp_tdata[17], rsp_tlast};
         if (crc_expect_q.size() == 0) begin
            note_failure($sformatf("unexpected response tdata=%h tlast=%b",
                                   rsp_tdata, rsp_tlast));
         end else begin
            want = crc_expect_q.pop_front();
            if (got !== want || rsp_tdata[RSP_DATA_W-1:18] !== '0) begin
               note_failure($sformatf(
                  "mismatch crc %h/%h err %b/%b pass %b/%b end %b/%b pad %h (exp/act)",
                  want.crc_value, got.crc_value, want.format_error, got.format_error,
                  want.check_pass, got.check_pass, want.message_end, got.message_end,
                  rsp_tdata[RSP_DATA_W-1:18]));
            end
         end
      end
   end

   // Main sequence
   initial begin
      int                    n_sent;
      int                    phase_items;
      int                    sel;
      bit                    paused;
      logic [CSR_DATA_W-1:0] gval;
      logic [CSR_DATA_W-1:0] vval;
      msg_kind_type          kind;

      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = CSR_GENERATOR;
      csr_wdata      = '0;
      crc_state      = '0;
      bad_char_seen  = 1'b0;
      gen_poly       = GENERATOR_RESET;
      verify_on      = 1'b0;
      fail_count     = 0;
      tx_idle_on     = 1'b1;
      rx_idle_on     = 1'b1;
      rx_hold_cycles = 0;
      paused         = 1'b0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table: boundaries of the digit ranges, message end, modes
      req_row("0",   1'b0, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b0);
      req_row("1",   1'b1, 1'b1, 16'h0589, 1'b0, 1'b0, 1'b1);
      req_row("F",   1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
      req_row("A",   1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
      req_row("9",   1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
      req_row("/",   1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
      req_row(":",   1'b1, 1'b0, '0, 1'b0, 1'b0, 1'b0);
      req_row("@",   1'b0, 1'b1, 16'h0000, 1'b1, 1'b0, 1'b0);
      req_row("G",   1'b1, 1'b1, 16'h0000, 1'b1, 1'b0, 1'b1);
      req_row("a",   1'b1, 1'b1, 16'h0000, 1'b1, 1'b0, 1'b1);
      req_row(8'h00, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b0, 1'b0);
      req_row(8'hFF, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0, 1'b1);
      req_row(8'h80, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0, 1'b1);
      csr_row(CSR_VERIFY_MODE, 16'h0001);
      // all-zero messages check out in verify mode; a lowercase or nonzero one does not
      req_row("0",   1'b1, 1'b1, 16'h0000, 1'b0, 1'b1, 1'b1);
      req_row("0",   1'b0, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b0);
      req_row("0",   1'b1, 1'b1, 16'h0000, 1'b0, 1'b1, 1'b1);
      req_row("f",   1'b1, 1'b1, 16'h0000, 1'b1, 1'b0, 1'b1);
      req_row("1",   1'b1, 1'b1, 16'h0589, 1'b0, 1'b0, 1'b1);
      csr_row(CSR_GENERATOR, 16'hFFFF);
      req_row("8",   1'b0, 1'b0, '0, 1'b0, 1'b0, 1'b0);
      req_row("E",   1'b1, 1'b0, '0, 1'b0, 1'b0, 1'b0);
      csr_row(CSR_GENERATOR, 16'h0000);
      req_row("F",   1'b1, 1'b1, 16'h0000, 1'b0, 1'b1, 1'b1);
      csr_row(CSR_VERIFY_MODE, 16'h0000);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            settle();
            csr_put(dir_rows[i].csr_sel, dir_rows[i].value);
         end else begin
            push_char(dir_rows[i].value[CHAR_W-1:0], dir_rows[i].is_last,
                      dir_rows[i].typed, dir_rows[i].want);
         end
      end

      // Random phases over several generator and mode settings
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         settle();
         case (ph)
            0, 1:    gval = GENERATOR_RESET;
            2, 3:    gval = 16'hFFFF;
            4:       gval = 16'h0000;
            5:       gval = 16'h8005;
            7:       gval = 16'h0001;
            default: gval = CSR_DATA_W'($urandom);
         endcase
         vval    = CSR_DATA_W'($urandom);
         vval[0] = (ph == 1 || ph == 3 || ph == 4 || ph == 6);
         csr_put(CSR_GENERATOR, gval);
         csr_put(CSR_VERIFY_MODE, vval);
         tx_idle_on = ($urandom_range(0, 3) != 0);
         rx_idle_on = ($urandom_range(0, 3) != 0);
         // long receiver hold with the sender streaming into it
         if (ph == 2) begin
            tx_idle_on     = 1'b0;
            rx_hold_cycles = 300;
         end
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            sel = $urandom_range(0, 99);
            kind = (sel < 70) ? MSG_GOOD : (sel < 88) ? MSG_BROKEN : MSG_NOISE;
            send_message(kind, n_sent);
            phase_items += n_sent;
            // sender waits for every response once, mid-phase
            if (ph == 5 && !paused && phase_items > PHASE_ITEMS / 2) begin
               paused = 1'b1;
               settle();
            end
            if ($urandom_range(0, 15) == 0) begin
               tx_idle_on = ~tx_idle_on;
            end
            if ($urandom_range(0, 15) == 0) begin
               rx_idle_on = ~rx_idle_on;
            end
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (crc_expect_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
